FILE: design/sha_pkg.sv
// sha_pkg: constants, types and round functions shared by the sha-256 stream hasher
// no dependencies
package sha_pkg;

  localparam int DataWidth     = 8;
  localparam int WordWidth     = 32;
  localparam int BlockBytes    = 64;
  localparam int ChainWords    = 8;
  localparam int Rounds        = 64;
  localparam int LenByteOffset = 56;
  localparam logic [7:0] PadByte = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_LOAD,
    ST_ROUND,
    ST_UPDATE,
    ST_EMIT
  } sha_state_t;

  // request from the controller to the compression core
  typedef struct packed {
    logic start;
  } sha_core_req_t;

  typedef struct packed {
    logic busy;
  } sha_core_stat_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k [0:63];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    round_k = k[r];
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h [0:7];
    h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    init_h = h[i];
  endfunction

endpackage

FILE: design/sha_core.sv
// sha_core: block buffer memory, schedule window and 64-round compression
// depends on sha_pkg
module sha_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [5:0]            wr_addr,
  input  logic [7:0]            wr_data,
  input  sha_pkg::sha_core_req_t req,
  input  logic                  chain_init,
  input  logic [2:0]            rd_idx,
  output logic [31:0]           rd_word,
  output sha_pkg::sha_core_stat_t stat
);
  import sha_pkg::*;

  // block buffer, one big-endian word per entry, byte-lane writes, word-wide synchronous read
  logic [31:0] blk_mem [0:BlockBytes/4-1];
  logic [31:0] chain_r [0:ChainWords-1];
  logic [31:0] w_r [0:15];
  logic [31:0] a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [1:0]  ph_r, ph_nxt;   // 0 idle, 1 load, 2 rounds, 3 update
  logic [31:0] rd_data_r;
  logic [3:0]  ld_addr;
  logic [31:0] w_now, s0, s1, w_new, t1, t2;
  logic [5:0]  rnd;

  assign ld_addr = cnt_r[3:0];
  assign rnd     = cnt_r[5:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      blk_mem[wr_addr[5:2]][{~wr_addr[1:0], 3'b000} +: 8] <= wr_data;
    end
    rd_data_r <= blk_mem[ld_addr];
  end

  always_comb begin
    s0 = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new = s1 + w_r[9] + s0 + w_r[0];
    w_now = (rnd < 6'd16) ? w_r[0] : w_new;
    t1 = h_r + (rotr(e_r, 6) ^ rotr(e_r, 11) ^ rotr(e_r, 25)) + ((e_r & f_r) ^ (~e_r & g_r))
         + round_k(rnd) + w_now;
    t2 = (rotr(a_r, 2) ^ rotr(a_r, 13) ^ rotr(a_r, 22)) ^ 32'd0;
    t2 = t2 + ((a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r));
  end

  always_comb begin
    ph_nxt  = ph_r;
    cnt_nxt = cnt_r;
    case (ph_r)
      2'd0: if (req.start) begin
        ph_nxt = 2'd1; cnt_nxt = '0;
      end
      2'd1: begin
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd16) begin
          ph_nxt = 2'd2; cnt_nxt = '0;
        end
      end
      2'd2: begin
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'(Rounds - 1)) ph_nxt = 2'd3;
      end
      default: ph_nxt = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= 2'd0;
      cnt_r <= '0;
    end else begin
      ph_r  <= ph_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // schedule window shifts: w_r[0] is always the current oldest word
  always_ff @(posedge clk) begin
    if (ph_r == 2'd1 && cnt_r != 7'd0) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= rd_data_r;
    end else if (ph_r == 2'd2) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_now;
    end
    if (ph_r == 2'd1 && cnt_r == 7'd16) begin
      a_r <= chain_r[0]; b_r <= chain_r[1]; c_r <= chain_r[2]; d_r <= chain_r[3];
      e_r <= chain_r[4]; f_r <= chain_r[5]; g_r <= chain_r[6]; h_r <= chain_r[7];
    end else if (ph_r == 2'd2) begin
      h_r <= g_r; g_r <= f_r; f_r <= e_r; e_r <= d_r + t1;
      d_r <= c_r; c_r <= b_r; b_r <= a_r; a_r <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || chain_init) begin
      for (int i = 0; i < ChainWords; i++) chain_r[i] <= init_h(3'(i));
    end else if (ph_r == 2'd3) begin
      chain_r[0] <= chain_r[0] + a_r; chain_r[1] <= chain_r[1] + b_r;
      chain_r[2] <= chain_r[2] + c_r; chain_r[3] <= chain_r[3] + d_r;
      chain_r[4] <= chain_r[4] + e_r; chain_r[5] <= chain_r[5] + f_r;
      chain_r[6] <= chain_r[6] + g_r; chain_r[7] <= chain_r[7] + h_r;
    end
  end

  assign rd_word   = chain_r[rd_idx];
  assign stat.busy = (ph_r != 2'd0);

endmodule

FILE: design/sha256_stream_hasher.sv
// sha256_stream_hasher: top level, byte intake, padding sequencer and digest output
// depends on sha_pkg and sha_core
//
// channel   dir  tdata fields (low bit up)             tuser / tlast
// in_       in   data_byte[7:0]                        tuser: has_byte, tlast: end_of_message
// out_      out  word_index[2:0], digest_word[34:3]    tlast: last_word
//
// one input transaction per cycle while no block is being compressed
// each full block stalls intake while the core compresses it (start request, load, 64 rounds, update)
// padding writes a byte per cycle if the core is idle; then 8 digest words leave one per cycle
// out_tvalid holds its word until out_tready; intake waits until the digest is gone
// reset (rst_n low, synchronous) loads the initial hash values and clears all counters
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tuser,   // has_byte
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // word_index, digest_word, zero fill
  output logic        out_tlast   // last_word
);
  import sha_pkg::*;

  sha_state_t     st_r, st_nxt;
  logic [5:0]     fill_r, fill_nxt;
  logic [63:0]    len_r, len_nxt, total_r, total_nxt;
  logic [2:0]     oidx_r, oidx_nxt;
  logic           pend_r, pend_nxt;     // a block start is owed to the core
  logic           wr_en;
  logic [7:0]     wr_data;
  logic           chain_init;
  logic [31:0]    rd_word;
  sha_core_req_t  req;
  sha_core_stat_t stat;
  logic           in_acc;

  sha_core u_core (
    .clk, .rst_n, .wr_en, .wr_addr(fill_r), .wr_data, .req, .chain_init,
    .rd_idx(oidx_r), .rd_word, .stat
  );

  assign in_acc = in_tvalid && in_tready;

  always_comb begin
    st_nxt = st_r; fill_nxt = fill_r; len_nxt = len_r; total_nxt = total_r;
    oidx_nxt = oidx_r; pend_nxt = pend_r;
    wr_en = 1'b0; wr_data = in_tdata; chain_init = 1'b0;
    in_tready = 1'b0; out_tvalid = 1'b0;
    req.start = 1'b0;
    // hand a filled block to the core once it is free
    if (pend_r && !stat.busy) begin
      req.start = 1'b1; pend_nxt = 1'b0;
    end
    case (st_r)
      ST_IDLE: begin
        in_tready = !pend_r && !stat.busy;
        if (in_acc) begin
          if (in_tuser) begin
            wr_en = 1'b1; fill_nxt = fill_r + 6'd1;
            if (fill_r == 6'd63) pend_nxt = 1'b1;
            len_nxt = len_r + 64'd8;
          end
          if (in_tlast) begin
            total_nxt = in_tuser ? len_r + 64'd8 : len_r;
            st_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        // first the 0x80 byte, then zeros until offset 56
        if (!pend_r && !stat.busy) begin
          wr_en = 1'b1;
          wr_data = (st_r == ST_PAD && total_nxt == total_r && oidx_r == 3'd0) ? PadByte : 8'd0;
          oidx_nxt = 3'd1;
          fill_nxt = fill_r + 6'd1;
          if (fill_r == 6'd63) pend_nxt = 1'b1;
          if (fill_nxt == 6'(LenByteOffset)) begin
            st_nxt = ST_LEN; oidx_nxt = '0;
          end
        end
      end
      ST_LEN: begin
        if (!pend_r && !stat.busy) begin
          wr_en = 1'b1;
          wr_data = total_r[63 - 8*fill_r[2:0] -: 8];
          fill_nxt = fill_r + 6'd1;
          if (fill_r == 6'd63) begin
            pend_nxt = 1'b1; st_nxt = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        if (!pend_r && !stat.busy) st_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            chain_init = 1'b1; len_nxt = '0; fill_nxt = '0; st_nxt = ST_IDLE;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign out_tdata = {5'd0, rd_word, oidx_r};
  assign out_tlast = (oidx_r == 3'd7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; fill_r <= '0; len_r <= '0; oidx_r <= '0; pend_r <= 1'b0;
    end else begin
      st_r <= st_nxt; fill_r <= fill_nxt; len_r <= len_nxt; oidx_r <= oidx_nxt;
      pend_r <= pend_nxt;
    end
    total_r <= total_nxt;
  end

endmodule

FILE: tb/tb_sha256_stream_hasher.sv
// testbench for sha256_stream_hasher: byte stream in, eight digest words out per message
// depends on sha_pkg and the sha256_stream_hasher rtl; the expected digests come from a
// behavioural sha-256 kept in a small scoreboard class
`timescale 1ns / 1ps

module tb_sha256_stream_hasher;
  import sha_pkg::*;

  // scoreboard: running sha-256 state plus the queue of digest words still owed
  class sha_digest_board;
    logic [31:0] chain [8];
    logic [7:0]  blk [64];
    logic [63:0] bit_count;
    int          fill;
    logic [31:0] owed_word [$];
    logic [2:0]  owed_idx [$];
    logic        owed_last [$];
    int          errors;
    int          messages;
    int          words_seen;

    function new();
      errors = 0;
      messages = 0;
      words_seen = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) chain[i] = init_h_value(i);
      bit_count = '0;
      fill = 0;
    endfunction

    function logic [31:0] init_h_value(int i);
      logic [31:0] iv [8];
      iv = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
             32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      return iv[i];
    endfunction

    function logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function logic [31:0] kval(int r);
      logic [31:0] k [64];
      k = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return k[r];
    endfunction

    function void compress();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2, s0, s1;
      for (int r = 0; r < 16; r++)
        w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
      for (int r = 16; r < 64; r++) begin
        s0 = ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3);
        s1 = ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10);
        w[r] = s1 + w[r-7] + s0 + w[r-16];
      end
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int r = 0; r < 64; r++) begin
        t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
             ((v[4] & v[5]) ^ (~v[4] & v[6])) + kval(r) + w[r];
        t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
             ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += v[i];
    endfunction

    function void absorb(logic [7:0] b);
      blk[fill] = b;
      fill = (fill + 1) % 64;
      if (fill == 0) compress();
    endfunction

    // accepted input transaction: absorb the byte and, at end of message, owe a digest
    function void note_input(logic [7:0] data, logic has, logic eom);
      logic [63:0] len;
      if (has) begin
        absorb(data);
        bit_count += 64'd8;
      end
      if (!eom) return;
      len = bit_count;
      absorb(PadByte);
      while (fill != LenByteOffset) absorb(8'h00);
      for (int i = 0; i < 8; i++) absorb(len[63-8*i -: 8]);
      for (int i = 0; i < 8; i++) begin
        owed_idx.push_back(i[2:0]);
        owed_word.push_back(chain[i]);
        owed_last.push_back(i == 7);
      end
      messages++;
      restart();
    endfunction

    // accepted output transaction: compare with the oldest owed word
    function void check_word(logic [39:0] tdata, logic tlast);
      logic [2:0] e_idx;
      logic [31:0] e_word;
      logic e_last;
      words_seen++;
      if (owed_word.size() == 0) begin
        $display("%0t: unexpected digest word idx=%0d word=%h", $time, tdata[2:0], tdata[34:3]);
        errors++;
        return;
      end
      e_idx = owed_idx.pop_front();
      e_word = owed_word.pop_front();
      e_last = owed_last.pop_front();
      if (tdata[2:0] !== e_idx) begin
        $display("%0t: word_index expected %0d actual %0d", $time, e_idx, tdata[2:0]);
        errors++;
      end
      if (tdata[34:3] !== e_word) begin
        $display("%0t: digest_word[%0d] expected %h actual %h", $time, e_idx, e_word,
                 tdata[34:3]);
        errors++;
      end
      if (tlast !== e_last) begin
        $display("%0t: last_word expected %0b actual %0b", $time, e_last, tlast);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // data_byte
  logic        in_tuser = 1'b0; // has_byte
  logic        in_tlast = 1'b0; // end_of_message
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // word_index[2:0], digest_word[34:3], zero fill
  logic        out_tlast;       // last_word

  sha_digest_board board = new();
  int  cycle_count = 0;
  int  bytes_sent = 0;
  int  items_sent = 0;
  int  out_hold = 0;
  // generous: ~170 items, each possibly ending a message, plus long stalls on both sides
  localparam int CycleLimit = 400000;

  always #6 clk = ~clk;

  sha256_stream_hasher dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  // mostly short gaps, now and then a long one, sometimes none at all
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one input transaction, after a random idle gap; valid stays high across back-to-back items
  task automatic send_item(logic [7:0] data, logic has, logic eom);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= has;
    in_tlast  <= eom;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_input(data, has, eom);
    items_sent++;
    if (has) bytes_sent++;
  endtask

  // a message of n random bytes; the end mark either rides on the last byte or on an empty item
  task automatic send_message(int n);
    bit empty_end;
    empty_end = (n == 0) || ($urandom_range(3) == 0);
    for (int i = 0; i < n; i++)
      send_item(8'($urandom_range(255)), 1'b1, (i == n - 1) && !empty_end);
    if (empty_end) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  // result side: random back-pressure with the odd long stall, checking every accepted word
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) board.check_word(out_tdata, out_tlast);
      if (out_hold > 0) begin
        out_tready <= 1'b0;
        out_hold   <= out_hold - 1;
      end else if ($urandom_range(99) < 4) begin
        out_tready <= 1'b0;
        out_hold   <= $urandom_range(8, 40);
      end else begin
        out_tready <= ($urandom_range(99) < 65);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("sha256_stream_hasher verification failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty message, extremes of the byte, idle no-op items, pad boundaries
    send_item(8'h00, 1'b0, 1'b1);                 // empty message
    send_item(8'hff, 1'b0, 1'b0);                 // no byte and no end: ignored
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'haa, 1'b0, 1'b0);                 // ignored in mid-message
    send_item(8'h55, 1'b1, 1'b1);                 // end on a byte
    send_item(8'h61, 1'b1, 1'b0);                 // "abc"
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_message(55);                             // length fits in one block
    send_message(56);                             // padding spills into a second block

    // random: mostly short messages, a few longer ones, the odd ignored item
    while (items_sent < 170) begin
      if ($urandom_range(9) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      else if ($urandom_range(9) == 0) send_message($urandom_range(13, 40));
      else send_message($urandom_range(0, 12));
    end
    in_tvalid <= 1'b0;

    while (board.owed_word.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("sent %0d items carrying %0d message bytes over %0d messages", items_sent,
             bytes_sent, board.messages);
    $display("checked %0d digest words with random stalls on both channels", board.words_seen);
    if (board.errors == 0) begin
      $display("sha256_stream_hasher verification clean");
    end else begin
      $display("sha256_stream_hasher verification failed");
    end
    $finish;
  end

endmodule

FILE: sha256_stream_hasher.f
design/sha_pkg.sv
design/sha_core.sv
design/sha256_stream_hasher.sv
tb/tb_sha256_stream_hasher.sv
